[hdl/sphk_pkg.sv]
package sphk_pkg;

	localparam int IN_FRAC_BITS  = 16;
	localparam int OUT_FRAC_BITS = 30;

	localparam int QB        = 30;
	localparam int OUT_SHIFT = QB - OUT_FRAC_BITS;
	localparam int HW        = 25;
	localparam int QW        = 32;
	localparam int PW        = 36;
	localparam int DIV_BPS   = 4;
	localparam int DIV_STAGES = QW / DIV_BPS;

	localparam logic [HW-1:0] ONE_H    = HW'(2 ** IN_FRAC_BITS);
	localparam logic [HW-1:0] INV_REM0 = HW'(2 ** (IN_FRAC_BITS - 2));
	localparam logic [28:0]   INV_PI_Q    = 29'd341782638;
	localparam logic [28:0]   QUAD_NORM_Q = 29'd320421223;
	localparam logic [PW-1:0] QONE        = PW'(2 ** QB);

	typedef struct packed {
		logic [23:0] distance;
		logic [23:0] smoothing_width;
		logic        kernel_select;
	} req_t;

	typedef struct packed {
		logic signed [31:0] kernel_value;
		logic signed [31:0] kernel_slope;
	} rsp_t;

	typedef struct packed {
		logic [HW-1:0] rem_s;
		logic [HW-1:0] rem_i;
		logic [QW-1:0] num;
		logic [QW-1:0] q_s;
		logic [QW-1:0] q_i;
		logic [HW-1:0] h;
		logic          quad;
		logic          far;
	} div_t;

	function automatic logic [35:0] qmul33(input logic [32:0] a, input logic [32:0] b);
		logic [65:0] p;
		p = 66'(a) * 66'(b);
		return p[65:30];
	endfunction

endpackage

[hdl/sph_kernel_evaluator.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall   sphk_pkg::req_t
// rsp       out        rsp_valid / rsp_stall   sphk_pkg::rsp_t
//
// One transaction is accepted per cycle while req_stall is low; the figure is set by a fully pipelined
// datapath with no shared unit.
// A request passes through one input stage, eight radix-16 divider stages,
// five multiply stages and the output register.
// Reset clears all valid bits; the data registers are not reset.
// A single skid register behind the pipeline takes the transaction that
// leaves it while the output is stalled; req_stall is high while it is full.
module sph_kernel_evaluator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  sphk_pkg::req_t   req_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output sphk_pkg::rsp_t   rsp_data
);

	logic en;

	sphk_pkg::div_t div_in;
	sphk_pkg::div_t div_s  [0:sphk_pkg::DIV_STAGES];
	sphk_pkg::div_t div_nx [1:sphk_pkg::DIV_STAGES];
	logic [sphk_pkg::DIV_STAGES:0] div_v_s;

	logic [31:0] s_s10;
	logic [30:0] inv_s10, inv2_s10;
	logic [32:0] s2_s10;
	logic        quad_s10, far_s10, v_s10;

	logic [30:0] inv_s11, inv3_s11, t_s11, t2_s11;
	logic [31:0] s_s11;
	logic [32:0] s2_s11;
	logic [29:0] s3_s11;
	logic        near_s11, quad_s11, far_s11, v_s11;

	logic [30:0] inv4_s12, t3_s12;
	logic [28:0] scale3_s12, norm_s12;
	logic [31:0] s_s12;
	logic [32:0] s2_s12;
	logic [29:0] s3_s12;
	logic signed [sphk_pkg::PW-1:0] pg_s12;
	logic        near_s12, quad_s12, far_s12, v_s12;

	logic [28:0] scale3_s13, scale4_s13;
	logic signed [sphk_pkg::PW-1:0] pw_s13, pg_s13;
	logic        quad_s13, far_s13, v_s13;

	logic [33:0] prodw_s14, prodg_s14;
	logic        negw_s14, negg_s14, far_s14, v_s14;

	logic           rsp_valid_q, skid_valid_q, out_ready;
	sphk_pkg::rsp_t rsp_q, skid_q, item;

	assign en        = !skid_valid_q;
	assign req_stall = skid_valid_q;
	assign out_ready = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		logic [sphk_pkg::HW-1:0] h;
		h = sphk_pkg::HW'(req_data.smoothing_width);
		if (h < sphk_pkg::ONE_H) begin
			h = sphk_pkg::ONE_H;
		end
		div_in.h     = h;
		div_in.far   = {2'b00, req_data.distance} > {h, 1'b0};
		div_in.quad  = req_data.kernel_select;
		div_in.rem_s = sphk_pkg::HW'(req_data.distance[23:2]);
		div_in.rem_i = sphk_pkg::INV_REM0;
		div_in.num   = {req_data.distance[1:0], 30'd0};
		div_in.q_s   = '0;
		div_in.q_i   = '0;
	end

	always_comb begin
		sphk_pkg::div_t st;
		logic [sphk_pkg::HW:0] ts, ti, hx;
		for (int k = 1; k <= sphk_pkg::DIV_STAGES; k++) begin
			st = div_s[k-1];
			hx = {1'b0, st.h};
			for (int b = 0; b < sphk_pkg::DIV_BPS; b++) begin
				ts = {st.rem_s, st.num[sphk_pkg::QW-1]};
				ti = {st.rem_i, 1'b0};
				if (ts >= hx) begin
					st.rem_s = sphk_pkg::HW'(ts - hx);
					st.q_s   = {st.q_s[sphk_pkg::QW-2:0], 1'b1};
				end else begin
					st.rem_s = ts[sphk_pkg::HW-1:0];
					st.q_s   = {st.q_s[sphk_pkg::QW-2:0], 1'b0};
				end
				if (ti >= hx) begin
					st.rem_i = sphk_pkg::HW'(ti - hx);
					st.q_i   = {st.q_i[sphk_pkg::QW-2:0], 1'b1};
				end else begin
					st.rem_i = ti[sphk_pkg::HW-1:0];
					st.q_i   = {st.q_i[sphk_pkg::QW-2:0], 1'b0};
				end
				st.num = {st.num[sphk_pkg::QW-2:0], 1'b0};
			end
			div_nx[k] = st;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= div_in;
			for (int k = 1; k <= sphk_pkg::DIV_STAGES; k++) begin
				div_s[k] <= div_nx[k];
			end
		end
	end

	// Stage 10: squares of s and of 1/h.
	always_ff @(posedge clk) begin
		logic [35:0] p_inv2, p_s2;
		p_inv2 = sphk_pkg::qmul33(33'(div_s[sphk_pkg::DIV_STAGES].q_i[30:0]),
			33'(div_s[sphk_pkg::DIV_STAGES].q_i[30:0]));
		p_s2 = sphk_pkg::qmul33(33'(div_s[sphk_pkg::DIV_STAGES].q_s),
			33'(div_s[sphk_pkg::DIV_STAGES].q_s));
		if (en) begin
			s_s10    <= div_s[sphk_pkg::DIV_STAGES].q_s;
			inv_s10  <= div_s[sphk_pkg::DIV_STAGES].q_i[30:0];
			inv2_s10 <= p_inv2[30:0];
			s2_s10   <= p_s2[32:0];
			quad_s10 <= div_s[sphk_pkg::DIV_STAGES].quad;
			far_s10  <= div_s[sphk_pkg::DIV_STAGES].far;
		end
	end

	// Stage 11: cubes and the distance to the outer support.
	always_ff @(posedge clk) begin
		logic [35:0] p_inv3, p_s3, p_t2;
		logic [31:0] t;
		t      = 32'h8000_0000 - s_s10;
		p_inv3 = sphk_pkg::qmul33(33'(inv2_s10), 33'(inv_s10));
		p_s3   = sphk_pkg::qmul33(33'(s2_s10[29:0]), 33'(s_s10[29:0]));
		p_t2   = sphk_pkg::qmul33(33'(t[30:0]), 33'(t[30:0]));
		if (en) begin
			inv_s11  <= inv_s10;
			inv3_s11 <= p_inv3[30:0];
			s_s11    <= s_s10;
			s2_s11   <= s2_s10;
			s3_s11   <= p_s3[29:0];
			t_s11    <= t[30:0];
			t2_s11   <= p_t2[30:0];
			near_s11 <= s_s10[31:30] == 2'b00;
			quad_s11 <= quad_s10;
			far_s11  <= far_s10;
		end
	end

	// Stage 12: fourth power of 1/h, the value scale and the gradient polynomial.
	always_ff @(posedge clk) begin
		logic [35:0] p_inv4, p_sc3, p_t3;
		logic [28:0] norm;
		logic signed [sphk_pkg::PW-1:0] pg;
		norm   = quad_s11 ? sphk_pkg::QUAD_NORM_Q : sphk_pkg::INV_PI_Q;
		p_inv4 = sphk_pkg::qmul33(33'(inv3_s11), 33'(inv_s11));
		p_sc3  = sphk_pkg::qmul33(33'(norm), 33'(inv3_s11));
		p_t3   = sphk_pkg::qmul33(33'(t2_s11), 33'(t_s11));
		if (quad_s11) begin
			pg = $signed(sphk_pkg::PW'(s_s11 >> 1)) - $signed(sphk_pkg::QONE);
		end else if (near_s11) begin
			pg = $signed((sphk_pkg::PW'(s2_s11) * sphk_pkg::PW'(9)) >> 2)
				- $signed(sphk_pkg::PW'(s_s11) * sphk_pkg::PW'(3));
		end else begin
			pg = -$signed((sphk_pkg::PW'(t2_s11) * sphk_pkg::PW'(3)) >> 2);
		end
		if (en) begin
			inv4_s12   <= p_inv4[30:0];
			scale3_s12 <= p_sc3[28:0];
			norm_s12   <= norm;
			t3_s12     <= p_t3[30:0];
			s_s12      <= s_s11;
			s2_s12     <= s2_s11;
			s3_s12     <= s3_s11;
			pg_s12     <= pg;
			near_s12   <= near_s11;
			quad_s12   <= quad_s11;
			far_s12    <= far_s11;
		end
	end

	// Stage 13: gradient scale and the value polynomial.
	always_ff @(posedge clk) begin
		logic [35:0] p_sc4;
		logic signed [sphk_pkg::PW-1:0] pw;
		p_sc4 = sphk_pkg::qmul33(33'(norm_s12), 33'(inv4_s12));
		if (quad_s12) begin
			pw = $signed(sphk_pkg::PW'(s2_s12 >> 2)) - $signed(sphk_pkg::PW'(s_s12))
				+ $signed(sphk_pkg::QONE);
		end else if (near_s12) begin
			pw = $signed(sphk_pkg::QONE)
				- $signed((sphk_pkg::PW'(s2_s12) * sphk_pkg::PW'(3)) >> 1)
				+ $signed((sphk_pkg::PW'(s3_s12) * sphk_pkg::PW'(3)) >> 2);
		end else begin
			pw = $signed(sphk_pkg::PW'(t3_s12 >> 2));
		end
		if (en) begin
			scale3_s13 <= scale3_s12;
			scale4_s13 <= p_sc4[28:0];
			pw_s13     <= pw;
			pg_s13     <= pg_s12;
			quad_s13   <= quad_s12;
			far_s13    <= far_s12;
		end
	end

	// Stage 14: magnitudes times their scales.
	always_ff @(posedge clk) begin
		logic [sphk_pkg::PW-1:0] mw, mg;
		logic [63:0] pwx, pgx;
		mw  = pw_s13[sphk_pkg::PW-1] ? sphk_pkg::PW'(-pw_s13) : sphk_pkg::PW'(pw_s13);
		mg  = pg_s13[sphk_pkg::PW-1] ? sphk_pkg::PW'(-pg_s13) : sphk_pkg::PW'(pg_s13);
		pwx = 64'(mw[34:0]) * 64'(scale3_s13);
		pgx = 64'(mg[34:0]) * 64'(scale4_s13);
		if (en) begin
			prodw_s14 <= pwx[63:30];
			prodg_s14 <= pgx[63:30];
			negw_s14  <= pw_s13[sphk_pkg::PW-1];
			negg_s14  <= pg_s13[sphk_pkg::PW-1];
			far_s14   <= far_s13;
		end
	end

	always_comb begin
		logic [33:0] shw, shg;
		shw = prodw_s14 >> sphk_pkg::OUT_SHIFT;
		shg = prodg_s14 >> sphk_pkg::OUT_SHIFT;
		if (far_s14) begin
			item.kernel_value = '0;
			item.kernel_slope = '0;
		end else begin
			item.kernel_value = $signed(negw_s14 ? 32'd0 - shw[31:0] : shw[31:0]);
			item.kernel_slope = $signed(negg_s14 ? 32'd0 - shg[31:0] : shg[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s      <= '0;
			v_s10        <= 1'b0;
			v_s11        <= 1'b0;
			v_s12        <= 1'b0;
			v_s13        <= 1'b0;
			v_s14        <= 1'b0;
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (en) begin
				div_v_s <= {div_v_s[sphk_pkg::DIV_STAGES-1:0], req_valid};
				v_s10   <= div_v_s[sphk_pkg::DIV_STAGES];
				v_s11   <= v_s10;
				v_s12   <= v_s11;
				v_s13   <= v_s12;
				v_s14   <= v_s13;
			end
			if (out_ready) begin
				if (skid_valid_q) begin
					rsp_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					rsp_valid_q <= v_s14;
				end
			end else if (v_s14 && !skid_valid_q) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			if (skid_valid_q) begin
				rsp_q <= skid_q;
			end else if (v_s14) begin
				rsp_q <= item;
			end
		end else if (v_s14 && !skid_valid_q) begin
			skid_q <= item;
		end
	end

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> rsp_valid_q)
		else $error("skid register holds a transaction while the output is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(rsp_valid_q && rsp_stall))
		else $error("skid register filled without an output stall");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_v_s[sphk_pkg::DIV_STAGES] && !div_s[sphk_pkg::DIV_STAGES].far |->
		div_s[sphk_pkg::DIV_STAGES].q_s <= 32'h8000_0000 &&
		div_s[sphk_pkg::DIV_STAGES].q_i <= 32'h4000_0000)
		else $error("divider quotient out of range for a near pair");

	a_quad_value_sign: assert property (@(posedge clk) disable iff (!arst_n)
		v_s13 && quad_s13 && !far_s13 |-> !pw_s13[sphk_pkg::PW-1])
		else $error("quadratic kernel polynomial went negative");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RANDOM_ITEMS   = 600;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	sphk_pkg::req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	sphk_pkg::rsp_t rsp_data;

	sphk_pkg::req_t pending[$];
	sphk_pkg::rsp_t kernel_expected[$];
	int   next_item;
	int   accepted_reqs;
	int   accepted_rsps;
	int   mismatches;
	int   burst_left;
	int   gap_left;
	int   stall_mode;
	int   stall_mode_left;
	int   idle_cycles;
	int   far_pairs;
	int   quad_pairs;

	sph_kernel_evaluator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
		return (a * b) >> 30;
	endfunction

	function automatic logic [31:0] fx_scale(longint signed poly, longint unsigned scale);
		longint unsigned mag;
		longint unsigned prod;
		mag = (poly < 0) ? longint'(-poly) : longint'(poly);
		prod = fx_mul(mag, scale) >> (30 - sphk_pkg::OUT_FRAC_BITS);
		return (poly < 0) ? 32'(-prod) : 32'(prod);
	endfunction

	function automatic sphk_pkg::rsp_t kernel_predict(sphk_pkg::req_t item);
		longint unsigned r, h, one_h, qone, s, inv_h, inv3, inv4, norm, s2, s3, t, t2, t3;
		longint signed pw, pg;
		sphk_pkg::rsp_t res;
		r = item.distance;
		h = item.smoothing_width;
		one_h = 64'd1 << sphk_pkg::IN_FRAC_BITS;
		qone = 64'd1 << 30;
		res = '0;
		if (h < one_h)
			h = one_h;
		if (r > 2 * h)
			return res;
		s = (r << 30) / h;
		inv_h = (64'd1 << (30 + sphk_pkg::IN_FRAC_BITS)) / h;
		inv3 = fx_mul(fx_mul(inv_h, inv_h), inv_h);
		inv4 = fx_mul(inv3, inv_h);
		s2 = fx_mul(s, s);
		if (!item.kernel_select) begin
			norm = 64'd341782638;
			if (s < qone) begin
				s3 = fx_mul(s2, s);
				pw = longint'(qone) - longint'((3 * s2) >> 1) + longint'((3 * s3) >> 2);
				pg = longint'((9 * s2) >> 2) - longint'(3 * s);
			end else begin
				t = 2 * qone - s;
				t2 = fx_mul(t, t);
				t3 = fx_mul(t2, t);
				pw = longint'(t3 >> 2);
				pg = -longint'((3 * t2) >> 2);
			end
		end else begin
			norm = 64'd320421223;
			pw = longint'(s2 >> 2) - longint'(s) + longint'(qone);
			pg = longint'(s >> 1) - longint'(qone);
		end
		res.kernel_value = fx_scale(pw, fx_mul(norm, inv3));
		res.kernel_slope = fx_scale(pg, fx_mul(norm, inv4));
		return res;
	endfunction

	function automatic sphk_pkg::req_t make_item(logic [23:0] r, logic [23:0] h, logic sel);
		sphk_pkg::req_t item;
		item.distance = r;
		item.smoothing_width = h;
		item.kernel_select = sel;
		return item;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int unsigned k;
		logic nv;
		sphk_pkg::req_t nd;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
			next_item <= 0;
			accepted_reqs <= 0;
			burst_left <= 1;
			gap_left <= 0;
			kernel_expected.delete();
		end else begin
			nv = req_valid;
			nd = req_data;
			if (req_valid && !req_stall) begin
				kernel_expected.push_back(kernel_predict(req_data));
				accepted_reqs <= accepted_reqs + 1;
			end
			if (!req_valid || !req_stall) begin
				nv = 1'b0;
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (next_item < pending.size()) begin
					nv = 1'b1;
					nd = pending[next_item];
					next_item <= next_item + 1;
					if (burst_left <= 1) begin
						k = $urandom_range(0, 3);
						burst_left <= (k == 0) ? 60 : $urandom_range(1, 12);
						gap_left <= (k == 1) ? 0 : $urandom_range(0, 5);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
			req_valid <= nv;
			req_data <= nd;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_mode <= 0;
			stall_mode_left <= 0;
		end else begin
			if (stall_mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_mode_left <= $urandom_range(5, 80);
			end else begin
				stall_mode_left <= stall_mode_left - 1;
			end
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				2: rsp_stall <= ($urandom_range(0, 3) != 0);
				default: rsp_stall <= ~rsp_stall;
			endcase
		end
	end

	always @(posedge clk or negedge arst_n) begin
		sphk_pkg::rsp_t want;
		int errs;
		if (!arst_n) begin
			accepted_rsps <= 0;
			mismatches <= 0;
		end else if (rsp_valid && !rsp_stall) begin
			errs = 0;
			accepted_rsps <= accepted_rsps + 1;
			if (kernel_expected.size() == 0) begin
				$display("%0t: unexpected result value %h slope %h", $time,
					rsp_data.kernel_value, rsp_data.kernel_slope);
				errs++;
			end else begin
				want = kernel_expected.pop_front();
				if (rsp_data.kernel_value !== want.kernel_value) begin
					$display("%0t: kernel_value expected %h actual %h", $time,
						want.kernel_value, rsp_data.kernel_value);
					errs++;
				end
				if (rsp_data.kernel_slope !== want.kernel_slope) begin
					$display("%0t: kernel_slope expected %h actual %h", $time,
						want.kernel_slope, rsp_data.kernel_slope);
					errs++;
				end
			end
			mismatches <= mismatches + errs;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired with %0d results outstanding", $time,
				kernel_expected.size());
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [23:0] h;
		logic [23:0] r;
		int unsigned k;
		far_pairs = 0;
		quad_pairs = 0;
		arst_n = 1'b0;
		for (int sel = 0; sel < 2; sel++) begin
			pending.push_back(make_item(24'd0, 24'd0, 1'(sel)));
			pending.push_back(make_item(24'h008000, 24'h000100, 1'(sel)));
			pending.push_back(make_item(24'h010000, 24'h010000, 1'(sel)));
			pending.push_back(make_item(24'h020000, 24'h010000, 1'(sel)));
			pending.push_back(make_item(24'h020001, 24'h010000, 1'(sel)));
			pending.push_back(make_item(24'hFFFFFF, 24'hFFFFFF, 1'(sel)));
			pending.push_back(make_item(24'hFFFFFF, 24'h010000, 1'(sel)));
			pending.push_back(make_item(24'd0, 24'hFFFFFF, 1'(sel)));
			pending.push_back(make_item(24'h7FFFFF, 24'h7FFFFF, 1'(sel)));
			pending.push_back(make_item(24'hFFFFFE, 24'h7FFFFF, 1'(sel)));
			pending.push_back(make_item(24'h00FFFF, 24'h010000, 1'(sel)));
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			k = $urandom_range(0, 9);
			case (k)
				0: h = 24'($urandom_range(0, 24'h00FFFF));
				1, 2: h = 24'($urandom);
				default: h = 24'($urandom_range(24'h010000, 24'h080000));
			endcase
			if (k == 3)
				r = 24'($urandom);
			else
				r = 24'($urandom_range(0, ((h < 24'h010000) ? 24'h010000 : h) * 9 / 4));
			pending.push_back(make_item(r, h, 1'($urandom_range(0, 1))));
		end
		foreach (pending[i]) begin
			if (pending[i].kernel_select)
				quad_pairs++;
			if (pending[i].distance > 2 * ((pending[i].smoothing_width < 24'h010000) ?
				25'h010000 : 25'(pending[i].smoothing_width)))
				far_pairs++;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (!(next_item == pending.size() && accepted_reqs == pending.size()
			&& !req_valid && kernel_expected.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Evaluated %0d particle pairs (%0d quadratic, %0d beyond 2h).",
			accepted_reqs, quad_pairs, far_pairs);
		$display("Checked %0d results with %0d mismatches.", accepted_rsps, mismatches);
		if (mismatches == 0 && kernel_expected.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
hdl/sphk_pkg.sv
hdl/sph_kernel_evaluator.sv
test/tb_top.sv
